FILE: design/crbm_pkg.sv
`default_nettype none
package crbm_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_PARTICLES);

  localparam logic OP_COLLIDE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_RANGE_ERR = 1'b1;

  typedef logic [MAX_PARTICLES-1:0] row_t;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } item_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] reach_count;
    logic             status;
  } result_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    row_t             wr_data;
  } mem_req_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_FINISH
  } ctrl_state_t;

  function automatic logic [CNT_W-1:0] row_popcount(input row_t row);
    logic [CNT_W-1:0] total;
    total = '0;
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      total = total + CNT_W'(row[i]);
    end
    return total;
  endfunction

  // columns below the active count
  function automatic row_t col_mask(input logic [CNT_W-1:0] n);
    row_t m;
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: design/collision_reach_bit_matrix.sv
`default_nettype none
// channel  | handshake                  | word
// item     | item_valid / item_ready    | item (operation, first_index, second_index)
// result   | result_valid / result_ready| result (reach_count, status)
// config   | cfg_wr_en                  | cfg_wr_data (particle_count)
//
// each word passes in order through: accept with row reads, merge and write of the first
// row, write of the second row with the result loaded into the output register.
// the single write port of the row memory sets the pace of a collision.
// a query counts its row in the finish state; errors still pass through every state.
// rst clears the fsm, the row valid bits (rows read as identity) and result_valid.
// a result held by result_ready stalls only the next word's last cycle.
module collision_reach_bit_matrix (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [crbm_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire crbm_pkg::item_word_t       item,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output crbm_pkg::result_word_t          result
);
  import crbm_pkg::*;

  mem_req_t     mem_req;
  row_t         rd_row_a;
  row_t         rd_row_b;
  logic         res_free;
  logic         res_load;
  result_word_t res_word;

  assign res_free = !result_valid || result_ready;

  crbm_row_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .rd_row_a (rd_row_a),
    .rd_row_b (rd_row_b)
  );

  crbm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .res_free    (res_free),
    .res_load    (res_load),
    .res_word    (res_word),
    .mem_req     (mem_req),
    .rd_row_a    (rd_row_a),
    .rd_row_b    (rd_row_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_word;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("accepted a word while one was in flight");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> !item_ready)
    else $error("row write outside an operation");

  a_err_zero_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_RANGE_ERR) |-> result.reach_count == '0)
    else $error("error result with nonzero count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.reach_count <= CNT_W'(MAX_PARTICLES))
    else $error("reach count above particle limit");

endmodule
`default_nettype wire

FILE: design/crbm_row_mem.sv
`default_nettype none
module crbm_row_mem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire crbm_pkg::mem_req_t req,
  output crbm_pkg::row_t         rd_row_a,
  output crbm_pkg::row_t         rd_row_b
);
  import crbm_pkg::*;

  row_t rows [MAX_PARTICLES];
  logic [MAX_PARTICLES-1:0] row_valid;

  row_t             raw_a;
  row_t             raw_b;
  logic             valid_a;
  logic             valid_b;
  logic [IDX_W-1:0] addr_a_q;
  logic [IDX_W-1:0] addr_b_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      rows[req.wr_addr] <= req.wr_data;
    end
    raw_a    <= rows[req.rd_addr_a];
    raw_b    <= rows[req.rd_addr_b];
    addr_a_q <= req.rd_addr_a;
    addr_b_q <= req.rd_addr_b;
  end

  // a row not written since reset reads as the identity row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      valid_a <= row_valid[req.rd_addr_a];
      valid_b <= row_valid[req.rd_addr_b];
    end
  end

  assign rd_row_a = valid_a ? raw_a : (row_t'(1) << addr_a_q);
  assign rd_row_b = valid_b ? raw_b : (row_t'(1) << addr_b_q);

endmodule
`default_nettype wire

FILE: design/crbm_ctrl.sv
`default_nettype none
module crbm_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [crbm_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire crbm_pkg::item_word_t       item,
  input  wire logic                       res_free,
  output logic                            res_load,
  output crbm_pkg::result_word_t          res_word,
  output crbm_pkg::mem_req_t              mem_req,
  input  wire crbm_pkg::row_t             rd_row_a,
  input  wire crbm_pkg::row_t             rd_row_b
);
  import crbm_pkg::*;

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [CNT_W-1:0] particle_count;
  logic [CNT_W-1:0] active_n;
  logic             op_q;
  logic [IDX_W-1:0] a_q;
  logic [IDX_W-1:0] b_q;
  logic             err_q;
  logic             err_next;
  row_t             row_q;
  logic             accept;
  logic             do_write;

  assign active_n = (particle_count > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                              : particle_count;
  assign accept = item_valid && item_ready;
  assign err_next = ({1'b0, item.first_index} >= active_n) ||
                    ((item.operation == OP_COLLIDE) && ({1'b0, item.second_index} >= active_n));
  assign do_write = (op_q == OP_COLLIDE) && !err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= CS_IDLE;
      particle_count <= COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        particle_count <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= item.operation;
      a_q   <= item.first_index;
      b_q   <= item.second_index;
      err_q <= err_next;
    end
    if (state == CS_READ) begin
      row_q <= (op_q == OP_COLLIDE) ? (rd_row_a | rd_row_b) : (rd_row_a & col_mask(active_n));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (accept) begin
          state_next = CS_READ;
        end
      end
      CS_READ: state_next = CS_FINISH;
      CS_FINISH: begin
        if (res_free) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    item_ready        = 1'b0;
    res_load          = 1'b0;
    mem_req.rd_addr_a = item.first_index;
    mem_req.rd_addr_b = item.second_index;
    mem_req.wr_en     = 1'b0;
    mem_req.wr_addr   = a_q;
    mem_req.wr_data   = rd_row_a | rd_row_b;
    res_word.status      = err_q ? ST_RANGE_ERR : ST_OK;
    res_word.reach_count = ((op_q == OP_QUERY) && !err_q) ? row_popcount(row_q) : '0;
    unique case (state)
      CS_IDLE: item_ready = 1'b1;
      CS_READ: begin
        // first row gets the merged row straight from the read data
        mem_req.wr_en = do_write;
      end
      CS_FINISH: begin
        // second row; rewriting while the result waits is harmless
        mem_req.wr_en   = do_write;
        mem_req.wr_addr = b_q;
        mem_req.wr_data = row_q;
        res_load        = res_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
